FILE: hw/rtl/mbb_pkg.sv
// shared constants and types for the monochrome bit blit engine
`default_nettype none
package mbb_pkg;

    localparam int SCREEN_WIDTH  = 800;
    localparam int SCREEN_HEIGHT = 480;
    localparam int ROW_BYTES     = 100;

    localparam int FRAME_BYTES = ROW_BYTES * SCREEN_HEIGHT;
    localparam int FB_AW       = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1;
    localparam int RB_W        = $clog2(4096 * ROW_BYTES);
    localparam int ADDR_W      = RB_W + 1;

    localparam int CFG_W = 11;
    localparam int IDX_W = 3;

    typedef enum logic [IDX_W-1:0] {
        CFG_DEST_X       = 3'd0,
        CFG_DEST_Y       = 3'd1,
        CFG_IMAGE_WIDTH  = 3'd2,
        CFG_IMAGE_HEIGHT = 3'd3,
        CFG_TRANSPARENT  = 3'd4
    } t_cfg_idx;

    typedef enum logic {
        OP_BLIT = 1'b0,
        OP_READ = 1'b1
    } t_op;

endpackage
`default_nettype wire

FILE: hw/rtl/mbb_ram.sv
// generic simple dual port ram, one write port and one registered read port
`default_nettype none
module mbb_ram #(
    parameter  int WIDTH = 8,
    parameter  int DEPTH = 1024,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

FILE: hw/rtl/mono_bit_blit_engine.sv
// top level of the monochrome 1bpp bit blit engine with its framebuffer
// Source image bytes and framebuffer reads enter on the input channel
// (i_in_valid / o_in_stall); every request gives one result on the output
// channel (o_out_valid / i_out_stall): read data for a read, image_done for
// a source byte. Geometry and mode are written on the configuration channel
// (i_cfg_valid / o_cfg_ready, always ready); any write to a defined index
// restarts the image. Each source byte touches two framebuffer bytes by
// read-modify-write; the single read port of the framebuffer ram takes
// both reads in turn. A new request can be accepted while the one before
// issues its last read. Each request passes the issue stage, the data stage
// and the result queue before o_out_valid rises. After reset the whole
// framebuffer is filled with 0xff, one byte a cycle, FRAME_BYTES (48000)
// bytes in all; o_in_stall stays high during that sweep.
// A two entry result queue sits in front of the output; while the receiver
// stalls, results wait there and o_in_stall rises once it cannot take more.
`default_nettype none
module mono_bit_blit_engine
    import mbb_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_stall,
    input  wire logic             i_operation,
    input  wire logic [7:0]       i_source_byte,
    input  wire logic [15:0]      i_read_address,
    output logic                  o_out_valid,
    input  wire logic             i_out_stall,
    output logic      [7:0]       o_read_data,
    output logic                  o_image_done,
    input  wire logic             i_cfg_valid,
    output logic                  o_cfg_ready,
    input  wire logic [IDX_W-1:0] i_cfg_index,
    input  wire logic [CFG_W-1:0] i_cfg_data
);

    // configuration
    logic [CFG_W-1:0] r_dest_x, n_dest_x;
    logic [CFG_W-1:0] r_dest_y, n_dest_y;
    logic [CFG_W-1:0] r_width, n_width;
    logic [CFG_W-1:0] r_height, n_height;
    logic             r_transp, n_transp;
    logic [RB_W-1:0]  r_top_base, n_top_base;
    logic             cfg_hit;

    // image position
    logic [CFG_W-1:0] r_row, n_row;
    logic [7:0]       r_col, n_col;
    logic [11:0]      r_cur_x, n_cur_x;
    logic [11:0]      r_cur_y, n_cur_y;
    logic [RB_W-1:0]  r_row_base, n_row_base;

    // clear sweep
    logic             r_clr_active;
    logic [FB_AW-1:0] r_clr_cnt;

    // issue stage
    logic              r_s_valid;
    logic              r_s_phase;
    logic              r_s_isread;
    logic [15:0]       r_s_raddr;
    logic [ADDR_W-1:0] r_s_addr;
    logic [15:0]       r_s_set16;
    logic [15:0]       r_s_clr16;
    logic              r_s_done;

    // data stage
    logic             r_d_valid;
    logic             r_d_final;
    logic             r_d_isread;
    logic             r_d_rd_ok;
    logic             r_d_write;
    logic             r_d_done;
    logic [FB_AW-1:0] r_d_addr;
    logic [7:0]       r_d_set8;
    logic [7:0]       r_d_clr8;

    // last write for forwarding
    logic             r_lw_en;
    logic [FB_AW-1:0] r_lw_addr;
    logic [7:0]       r_lw_data;

    // result queue
    logic [7:0] r_q_data [2];
    logic       r_q_done [2];
    logic       r_q_wp;
    logic       r_q_rp;
    logic [1:0] r_q_cnt;

    logic accept;
    logic is_read_in;
    logic [8:0] stride;
    logic empty_img;
    logic [8:0] col_next;
    logic [11:0] row_next;
    logic row_wrap;
    logic img_end;
    logic item_done;
    logic [10:0] col_px;
    logic y_ok;
    logic [7:0] mask8;
    logic [7:0] set8;
    logic [7:0] clr8;
    logic [15:0] set16;
    logic [15:0] clr16;
    logic [ADDR_W-1:0] addr0;

    logic s_last;
    logic q_room;
    logic issue;
    logic s_final_issue;
    logic [ADDR_W-1:0] addr_p;
    logic addr_ok;
    logic [FB_AW-1:0] ram_raddr;

    logic [7:0] ram_q;
    logic [7:0] old_byte;
    logic [7:0] new_byte;
    logic ram_we;
    logic [FB_AW-1:0] ram_waddr;
    logic [7:0] ram_wdata;
    logic push;
    logic pop;

    assign o_cfg_ready = 1'b1;
    assign cfg_hit     = i_cfg_valid && (i_cfg_index <= IDX_W'(CFG_TRANSPARENT));

    always_comb begin
        n_dest_x   = r_dest_x;
        n_dest_y   = r_dest_y;
        n_width    = r_width;
        n_height   = r_height;
        n_transp   = r_transp;
        n_top_base = r_top_base;
        if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_DEST_X: begin
                    n_dest_x = i_cfg_data;
                end
                CFG_DEST_Y: begin
                    n_dest_y   = i_cfg_data;
                    n_top_base = RB_W'(RB_W'(i_cfg_data) * RB_W'(ROW_BYTES));
                end
                CFG_IMAGE_WIDTH: begin
                    n_width = i_cfg_data;
                end
                CFG_IMAGE_HEIGHT: begin
                    n_height = i_cfg_data;
                end
                CFG_TRANSPARENT: begin
                    n_transp = i_cfg_data[0];
                end
                default: begin
                    n_transp = r_transp;
                end
            endcase
        end
    end

    // per request geometry
    always_comb begin
        stride    = 9'(({1'b0, r_width} + 12'd7) >> 3);
        empty_img = (stride == 9'd0) || (r_height == '0) || (r_row >= r_height);
        col_next  = {1'b0, r_col} + 9'd1;
        row_next  = {1'b0, r_row} + 12'd1;
        row_wrap  = (col_next >= stride);
        img_end   = row_wrap && (row_next >= {1'b0, r_height});
        item_done = empty_img || img_end;
        col_px    = {r_col, 3'b000};
        y_ok      = (r_cur_y < 12'(SCREEN_HEIGHT));
        for (int b = 0; b < 8; b++) begin
            mask8[3'(7 - b)] = !empty_img && y_ok
                && (({1'b0, col_px} + 12'(b)) < {1'b0, r_width})
                && (({1'b0, r_cur_x} + 13'(b)) < 13'(SCREEN_WIDTH));
        end
        set8  = mask8 & i_source_byte & {8{!r_transp}};
        clr8  = mask8 & ~i_source_byte;
        set16 = {set8, 8'h00} >> r_cur_x[2:0];
        clr16 = {clr8, 8'h00} >> r_cur_x[2:0];
        addr0 = ADDR_W'(r_row_base) + ADDR_W'(r_cur_x[11:3]);
    end

    assign is_read_in = (t_op'(i_operation) == OP_READ);

    always_comb begin
        n_row      = r_row;
        n_col      = r_col;
        n_cur_x    = r_cur_x;
        n_cur_y    = r_cur_y;
        n_row_base = r_row_base;
        if (cfg_hit) begin
            n_row      = '0;
            n_col      = '0;
            n_cur_x    = {1'b0, n_dest_x};
            n_cur_y    = {1'b0, n_dest_y};
            n_row_base = n_top_base;
        end else if (accept && !is_read_in) begin
            if (empty_img || img_end) begin
                n_row      = '0;
                n_col      = '0;
                n_cur_x    = {1'b0, r_dest_x};
                n_cur_y    = {1'b0, r_dest_y};
                n_row_base = r_top_base;
            end else if (row_wrap) begin
                n_row      = row_next[CFG_W-1:0];
                n_col      = '0;
                n_cur_x    = {1'b0, r_dest_x};
                n_cur_y    = r_cur_y + 12'd1;
                n_row_base = r_row_base + RB_W'(ROW_BYTES);
            end else begin
                n_col   = col_next[7:0];
                n_cur_x = r_cur_x + 12'd8;
            end
        end
    end

    // issue control
    assign s_last        = r_s_isread || r_s_phase;
    assign q_room        = (r_q_cnt == 2'd0) || ((r_q_cnt == 2'd1) && !(r_d_valid && r_d_final));
    assign issue         = r_s_valid && !r_clr_active && (!s_last || q_room);
    assign s_final_issue = issue && s_last;
    assign o_in_stall    = r_clr_active || (r_s_valid && !s_final_issue);
    assign accept        = i_in_valid && !o_in_stall;

    assign addr_p    = r_s_addr + ADDR_W'(r_s_phase);
    assign addr_ok   = (addr_p < ADDR_W'(FRAME_BYTES));
    assign ram_raddr = r_s_isread ? FB_AW'(r_s_raddr) : addr_p[FB_AW-1:0];

    // data stage merge with forwarding of the previous write
    assign old_byte = (r_lw_en && (r_lw_addr == r_d_addr)) ? r_lw_data : ram_q;
    assign new_byte = (old_byte & ~r_d_clr8) | r_d_set8;

    always_comb begin
        if (r_clr_active) begin
            ram_we    = 1'b1;
            ram_waddr = r_clr_cnt;
            ram_wdata = 8'hff;
        end else begin
            ram_we    = r_d_valid && r_d_write;
            ram_waddr = r_d_addr;
            ram_wdata = new_byte;
        end
    end

    mbb_ram #(
        .WIDTH (8),
        .DEPTH (FRAME_BYTES)
    ) u_frame (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (issue),
        .i_raddr (ram_raddr),
        .o_rdata (ram_q)
    );

    assign push = r_d_valid && r_d_final;
    assign pop  = o_out_valid && !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dest_x     <= '0;
            r_dest_y     <= '0;
            r_width      <= '0;
            r_height     <= '0;
            r_transp     <= 1'b0;
            r_top_base   <= '0;
            r_row        <= '0;
            r_col        <= '0;
            r_cur_x      <= '0;
            r_cur_y      <= '0;
            r_row_base   <= '0;
            r_clr_active <= 1'b1;
            r_clr_cnt    <= '0;
            r_s_valid    <= 1'b0;
            r_s_phase    <= 1'b0;
            r_d_valid    <= 1'b0;
            r_lw_en      <= 1'b0;
            r_q_wp       <= 1'b0;
            r_q_rp       <= 1'b0;
            r_q_cnt      <= '0;
        end else begin
            r_dest_x   <= n_dest_x;
            r_dest_y   <= n_dest_y;
            r_width    <= n_width;
            r_height   <= n_height;
            r_transp   <= n_transp;
            r_top_base <= n_top_base;
            r_row      <= n_row;
            r_col      <= n_col;
            r_cur_x    <= n_cur_x;
            r_cur_y    <= n_cur_y;
            r_row_base <= n_row_base;
            if (r_clr_active) begin
                r_clr_cnt <= r_clr_cnt + FB_AW'(1);
                if (r_clr_cnt == FB_AW'(FRAME_BYTES - 1)) begin
                    r_clr_active <= 1'b0;
                end
            end
            if (accept) begin
                r_s_valid <= 1'b1;
                r_s_phase <= 1'b0;
            end else if (s_final_issue) begin
                r_s_valid <= 1'b0;
                r_s_phase <= 1'b0;
            end else if (issue) begin
                r_s_phase <= 1'b1;
            end
            r_d_valid <= issue;
            r_lw_en   <= ram_we;
            if (push) begin
                r_q_wp <= ~r_q_wp;
            end
            if (pop) begin
                r_q_rp <= ~r_q_rp;
            end
            r_q_cnt <= r_q_cnt + 2'(push) - 2'(pop);
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s_isread <= is_read_in;
            r_s_raddr  <= i_read_address;
            r_s_addr   <= addr0;
            r_s_set16  <= is_read_in ? 16'h0000 : set16;
            r_s_clr16  <= is_read_in ? 16'h0000 : clr16;
            r_s_done   <= !is_read_in && item_done;
        end
        if (issue) begin
            r_d_final  <= s_last;
            r_d_isread <= r_s_isread;
            r_d_rd_ok  <= (32'(r_s_raddr) < 32'(FRAME_BYTES));
            r_d_write  <= !r_s_isread && addr_ok;
            r_d_done   <= r_s_done;
            r_d_addr   <= ram_raddr;
            r_d_set8   <= r_s_phase ? r_s_set16[7:0] : r_s_set16[15:8];
            r_d_clr8   <= r_s_phase ? r_s_clr16[7:0] : r_s_clr16[15:8];
        end
        r_lw_addr <= ram_waddr;
        r_lw_data <= ram_wdata;
        if (push) begin
            r_q_data[r_q_wp] <= (r_d_isread && r_d_rd_ok) ? old_byte : 8'h00;
            r_q_done[r_q_wp] <= r_d_done;
        end
    end

    assign o_out_valid  = (r_q_cnt != 2'd0);
    assign o_read_data  = r_q_data[r_q_rp];
    assign o_image_done = r_q_done[r_q_rp];

    // result queue never takes a result it has no room for
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> ((r_q_cnt != 2'd2) || pop))
        else $error("result queue overflow");

    // no framebuffer access from the datapath while the clear sweep runs
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_active |-> !r_d_valid)
        else $error("datapath active during clear sweep");

    // only source bytes use the second byte slot
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s_valid && r_s_phase) |-> !r_s_isread)
        else $error("read request in second slot");

    // a source byte issues both slots on consecutive issues before leaving
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (issue && !s_last) |=> (r_s_valid && r_s_phase))
        else $error("second slot lost");

endmodule
`default_nettype wire

FILE: bench/mono_bit_blit_engine_tb.sv
`timescale 1ns / 1ps
// self-checking testbench for the monochrome bit blit engine
module mono_bit_blit_engine_tb;
    import mbb_pkg::*;

    localparam int unsigned ITEM_TARGET = 1850;
    localparam int unsigned HOLD_CYCLES = 300;

    typedef struct packed {
        logic [7:0] data;
        logic       done;
    } t_blit_result;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_in_valid = 1'b0;
    logic             o_in_stall;
    logic             i_operation = 1'b0;
    logic [7:0]       i_source_byte = 8'h00;
    logic [15:0]      i_read_address = 16'h0000;
    logic             o_out_valid;
    logic             i_out_stall = 1'b0;
    logic [7:0]       o_read_data;
    logic             o_image_done;
    logic             i_cfg_valid = 1'b0;
    logic             o_cfg_ready;
    logic [IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_W-1:0] i_cfg_data = '0;

    mono_bit_blit_engine DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_operation   (i_operation),
        .i_source_byte (i_source_byte),
        .i_read_address(i_read_address),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_read_data   (o_read_data),
        .o_image_done  (o_image_done),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // framebuffer mirror and blit position
    logic [7:0]   fb_mirror [FRAME_BYTES];
    int unsigned  org_x = 0;
    int unsigned  org_y = 0;
    int unsigned  img_w = 0;
    int unsigned  img_h = 0;
    int unsigned  cur_row = 0;
    int unsigned  cur_col = 0;
    logic         clear_only = 1'b0;

    t_blit_result expected_results [$];
    t_blit_result want_res;
    int unsigned  mismatches = 0;
    int unsigned  items_sent = 0;
    int unsigned  burst_left = 0;
    int unsigned  max_gap = 0;
    int unsigned  stall_pct = 0;
    logic         hold_active = 1'b0;

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #20_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic void plot_pixel(int unsigned px, int unsigned py, logic pix);
        int unsigned addr;
        if (px >= SCREEN_WIDTH || py >= SCREEN_HEIGHT) return;
        addr = py * ROW_BYTES + (px >> 3);
        if (addr >= FRAME_BYTES) return;
        if (pix) begin
            if (!clear_only) fb_mirror[16'(addr)][3'(7 - (px & 7))] = 1'b1;
        end else begin
            fb_mirror[16'(addr)][3'(7 - (px & 7))] = 1'b0;
        end
    endfunction

    function automatic t_blit_result predict_request(t_op op, logic [7:0] sb, logic [15:0] ra);
        t_blit_result res;
        int unsigned  stride;
        int unsigned  b;
        res = '0;
        if (op == OP_READ) begin
            if (32'(ra) < FRAME_BYTES) res.data = fb_mirror[ra];
            return res;
        end
        stride = (img_w + 7) >> 3;
        if (stride == 0 || img_h == 0 || cur_row >= img_h) begin
            cur_row  = 0;
            cur_col  = 0;
            res.done = 1'b1;
            return res;
        end
        for (b = 0; b < 8; b++) begin
            if (cur_col * 8 + b < img_w)
                plot_pixel(org_x + cur_col * 8 + b, org_y + cur_row, sb[3'(7 - b)]);
        end
        cur_col++;
        if (cur_col >= stride) begin
            cur_col = 0;
            cur_row++;
            if (cur_row >= img_h) begin
                cur_row  = 0;
                res.done = 1'b1;
            end
        end
        return res;
    endfunction

    function automatic void mirror_reg(t_cfg_idx idx, logic [CFG_W-1:0] val);
        case (idx)
            CFG_DEST_X:       org_x = 32'(val);
            CFG_DEST_Y:       org_y = 32'(val);
            CFG_IMAGE_WIDTH:  img_w = 32'(val);
            CFG_IMAGE_HEIGHT: img_h = 32'(val);
            CFG_TRANSPARENT:  clear_only = val[0];
            default: return;
        endcase
        cur_row = 0;
        cur_col = 0;
    endfunction

    // mostly addresses inside the current image area
    function automatic logic [15:0] pick_read_address();
        int unsigned roll;
        int unsigned addr;
        logic [15:0] ra;
        roll = $urandom_range(99);
        if (roll < 10) begin
            addr = $urandom_range(65535);
        end else if (roll < 30) begin
            addr = $urandom_range(FRAME_BYTES - 1);
        end else begin
            addr = (org_y + $urandom_range(img_h)) * ROW_BYTES + (org_x >> 3)
                + $urandom_range((img_w + 7) >> 3);
            if (addr >= FRAME_BYTES) addr = $urandom_range(FRAME_BYTES - 1);
        end
        ra = addr[15:0];
        return ra;
    endfunction

    always @(posedge i_clk) begin
        if (hold_active)
            i_out_stall <= 1'b1;
        else
            i_out_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: read_data %02h image_done %0b",
                        o_read_data, o_image_done);
            end else begin
                want_res = expected_results.pop_front();
                if (o_read_data !== want_res.data || o_image_done !== want_res.done) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: data exp %02h got %02h, done exp %0b got %0b",
                            want_res.data, o_read_data, want_res.done, o_image_done);
                end
            end
        end
    end

    task automatic send_request(t_op op, logic [7:0] sb, logic [15:0] ra);
        int unsigned gap;
        if (burst_left == 0) begin
            gap = $urandom_range(max_gap);
            if (gap != 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(24, 1);
        end
        burst_left--;
        i_in_valid     <= 1'b1;
        i_operation    <= op;
        i_source_byte  <= sb;
        i_read_address <= ra;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        expected_results.push_back(predict_request(op, sb, ra));
        items_sent++;
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        burst_left = 0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [CFG_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        mirror_reg(idx, val);
        @(posedge i_clk);
    endtask

    task automatic setup_image(logic [CFG_W-1:0] x, y, w, h, logic t);
        wait_idle();
        write_reg(CFG_DEST_X, x);
        write_reg(CFG_DEST_Y, y);
        write_reg(CFG_IMAGE_WIDTH, w);
        write_reg(CFG_IMAGE_HEIGHT, h);
        write_reg(CFG_TRANSPARENT, {{(CFG_W-1){1'b0}}, t});
    endtask

    task automatic test_reset_state();
        send_request(OP_READ, 8'hA5, 16'd0);
        send_request(OP_READ, 8'h5A, 16'hFFFF);
        send_request(OP_READ, 8'h00, 16'(FRAME_BYTES));
        send_request(OP_BLIT, 8'h00, 16'h1234);
    endtask

    task automatic test_opaque_blit();
        setup_image(3, 5, 10, 2, 1'b0);
        send_request(OP_BLIT, 8'h00, 16'h0000);
        send_request(OP_BLIT, 8'hFF, 16'hFFFF);
        send_request(OP_BLIT, 8'hA5, 16'h0000);
        send_request(OP_BLIT, 8'h5A, 16'h0000);
        send_request(OP_READ, 8'hFF, 16'(5 * ROW_BYTES));
        send_request(OP_READ, 8'h00, 16'(6 * ROW_BYTES + 1));
    endtask

    task automatic test_transparent_blit();
        setup_image(3, 5, 10, 2, 1'b1);
        send_request(OP_BLIT, 8'hFF, 16'h0000);
        send_request(OP_BLIT, 8'h0F, 16'h0000);
        send_request(OP_BLIT, 8'h00, 16'h0000);
        send_request(OP_BLIT, 8'hF0, 16'h0000);
        send_request(OP_READ, 8'h00, 16'(5 * ROW_BYTES));
        send_request(OP_READ, 8'h00, 16'(6 * ROW_BYTES));
    endtask

    task automatic test_clipping();
        setup_image(795, 479, 16, 2, 1'b0);
        repeat (4) send_request(OP_BLIT, 8'h00, 16'h0000);
        send_request(OP_READ, 8'h00, 16'(FRAME_BYTES - 1));
        setup_image(11'h7FF, 11'h7FF, 11'h7FF, 11'h7FF, 1'b1);
        send_request(OP_BLIT, 8'h00, 16'h0000);
        wait_idle();
        write_reg(CFG_IMAGE_HEIGHT, 11'd0);
        send_request(OP_BLIT, 8'h00, 16'h0000);
    endtask

    task automatic test_register_restart();
        setup_image(0, 0, 16, 1, 1'b0);
        send_request(OP_BLIT, 8'h00, 16'h0000);
        wait_idle();
        write_reg(CFG_DEST_X, 11'd16);
        send_request(OP_BLIT, 8'h00, 16'h0000);
        send_request(OP_BLIT, 8'h00, 16'h0000);
        send_request(OP_READ, 8'h00, 16'd0);
        send_request(OP_READ, 8'h00, 16'd2);
    endtask

    task automatic test_backpressure();
        int unsigned k;
        setup_image(100, 50, 24, 4, 1'b0);
        stall_pct <= 0;
        max_gap = 0;
        fork
            begin
                hold_active <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_active <= 1'b0;
            end
        join_none
        for (k = 0; k < 40; k++) begin
            send_request(OP_BLIT, 8'($urandom_range(255)), 16'($urandom_range(65535)));
            if (k % 4 == 3)
                send_request(OP_READ, 8'($urandom_range(255)), pick_read_address());
        end
    endtask

    task automatic test_random_images();
        logic [CFG_W-1:0] x, y, w, h;
        int unsigned roll;
        int unsigned n_bytes;
        int unsigned k;
        while (items_sent < ITEM_TARGET) begin
            roll = $urandom_range(2);
            stall_pct <= (roll == 0) ? 0 : (roll == 1) ? 25 : 60;
            roll = $urandom_range(2);
            max_gap = (roll == 0) ? 0 : (roll == 1) ? 3 : 10;

            roll = $urandom_range(99);
            if (roll < 80) begin
                x = CFG_W'($urandom_range(799));
                y = CFG_W'($urandom_range(479));
            end else if (roll < 90) begin
                x = CFG_W'($urandom_range(805, 780));
                y = CFG_W'($urandom_range(485, 470));
            end else begin
                x = CFG_W'($urandom_range(2047));
                y = CFG_W'($urandom_range(2047));
            end

            roll = $urandom_range(199);
            if (roll < 3) begin
                w = 11'h7FF;
                h = 11'd1;
            end else if (roll < 6) begin
                w = CFG_W'($urandom_range(2047, 100));
                h = 11'd1;
            end else if (roll < 14) begin
                w = ($urandom_range(1) != 0) ? '0 : CFG_W'($urandom_range(40));
                h = (w == '0) ? CFG_W'($urandom_range(5)) : '0;
            end else if (roll < 30) begin
                w = CFG_W'($urandom_range(8, 1));
                h = CFG_W'($urandom_range(40, 1));
            end else begin
                w = CFG_W'($urandom_range(48, 1));
                h = CFG_W'($urandom_range(8, 1));
            end
            setup_image(x, y, w, h, 1'($urandom_range(1)));

            n_bytes = ((32'(w) + 7) >> 3) * 32'(h);
            if (n_bytes == 0) n_bytes = $urandom_range(3, 1);
            roll = $urandom_range(99);
            // cut short or run past the end of the image
            if (roll < 12)
                n_bytes = $urandom_range(n_bytes);
            else if (roll < 20)
                n_bytes += $urandom_range(6, 1);

            for (k = 0; k < n_bytes; k++) begin
                if ($urandom_range(3) == 0)
                    send_request(OP_READ, 8'($urandom_range(255)), pick_read_address());
                send_request(OP_BLIT, 8'($urandom_range(255)), 16'($urandom_range(65535)));
            end
            repeat ($urandom_range(6, 1))
                send_request(OP_READ, 8'($urandom_range(255)), pick_read_address());
        end
    endtask

    initial begin
        for (int a = 0; a < FRAME_BYTES; a++) fb_mirror[16'(a)] = 8'hFF;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_state();
        test_opaque_blit();
        test_transparent_blit();
        test_clipping();
        test_register_restart();
        test_backpressure();
        test_random_images();

        wait_idle();
        if (mismatches == 0 && expected_results.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
